@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WSD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WSD_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/wsd_pkg.sv @@
// Types and constants of the WebSocket frame deframer.
`default_nettype none
package wsd_pkg;

    localparam logic [6:0] LEN16_CODE = 7'd126;
    localparam logic [6:0] LEN64_CODE = 7'd127;
    localparam logic [3:0] OP_TEXT    = 4'h1;
    localparam logic [3:0] OP_BINARY  = 4'h2;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key_byte;
        logic       kind;
        logic       fin;
        logic       last;
    } entry_t;

endpackage
`default_nettype wire

@@ hw/rtl/wsd_front.sv @@
// Header parser: takes stream bytes and queues payload bytes of data frames.
`default_nettype none
`include "assert_macros.svh"
module wsd_front #(
    parameter int LENGTH_BITS = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          queue_full,
    output logic               push,
    output wsd_pkg::entry_t    push_entry
);

    typedef enum logic [2:0] {
        PH_HDR1 = 3'd0,
        PH_HDR2 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [3:0]             opcode_reg, opcode_next;
    logic                   fin_reg, fin_next;
    logic                   masked_reg, masked_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [LENGTH_BITS-1:0] len_shift;
    logic [2:0]             ext_reg, ext_next;
    logic [31:0]            key_reg, key_next;
    logic [1:0]             pos_reg, pos_next;
    logic                   accept;
    logic                   emit;
    logic [7:0]             key_byte;

    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;
    assign emit      = (opcode_reg == wsd_pkg::OP_TEXT) || (opcode_reg == wsd_pkg::OP_BINARY);
    assign len_shift = {len_reg[LENGTH_BITS-9:0], rx_byte};

    always_comb
    begin
        unique case (pos_reg)
            2'd0: key_byte = key_reg[31:24];
            2'd1: key_byte = key_reg[23:16];
            2'd2: key_byte = key_reg[15:8];
            2'd3: key_byte = key_reg[7:0];
        endcase
        if (!masked_reg)
        begin
            key_byte = 8'h00;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        fin_next    = fin_reg;
        masked_next = masked_reg;
        len_next    = len_reg;
        ext_next    = ext_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        push        = 1'b0;
        push_entry.data     = rx_byte;
        push_entry.key_byte = key_byte;
        push_entry.kind     = (opcode_reg == wsd_pkg::OP_BINARY);
        push_entry.fin      = fin_reg;
        push_entry.last     = (len_reg == LENGTH_BITS'(1));
        if (accept)
        begin
            unique case (phase_reg)
                PH_HDR2:
                begin
                    masked_next = rx_byte[7];
                    key_next    = 32'h0;
                    len_next    = '0;
                    if (rx_byte[6:0] == wsd_pkg::LEN16_CODE)
                    begin
                        ext_next   = 3'd2;
                        phase_next = PH_EXT;
                    end
                    else if (rx_byte[6:0] == wsd_pkg::LEN64_CODE)
                    begin
                        ext_next   = 3'd0;   // eight bytes, counted as 0,7..1
                        phase_next = PH_EXT;
                    end
                    else
                    begin
                        len_next = LENGTH_BITS'(rx_byte[6:0]);
                        pos_next = 2'd0;
                        if (rx_byte[7])
                        begin
                            phase_next = PH_KEY;
                        end
                        else
                        begin
                            phase_next = (rx_byte[6:0] != 7'd0) ? PH_DATA : PH_HDR1;
                        end
                    end
                end
                PH_EXT:
                begin
                    len_next = len_shift;
                    ext_next = ext_reg - 3'd1;
                    if (ext_reg == 3'd1)
                    begin
                        pos_next = 2'd0;
                        if (masked_reg)
                        begin
                            phase_next = PH_KEY;
                        end
                        else
                        begin
                            phase_next = (len_shift != '0) ? PH_DATA : PH_HDR1;
                        end
                    end
                end
                PH_KEY:
                begin
                    key_next = {key_reg[23:0], rx_byte};
                    if (pos_reg == 2'd3)
                    begin
                        pos_next   = 2'd0;
                        phase_next = (len_reg != '0) ? PH_DATA : PH_HDR1;
                    end
                    else
                    begin
                        pos_next = pos_reg + 2'd1;
                    end
                end
                PH_DATA:
                begin
                    push     = emit;
                    pos_next = pos_reg + 2'd1;
                    len_next = len_reg - LENGTH_BITS'(1);
                    if (len_reg == LENGTH_BITS'(1))
                    begin
                        phase_next = PH_HDR1;
                    end
                end
                default:
                begin
                    fin_next    = rx_byte[7];
                    opcode_next = rx_byte[3:0];
                    phase_next  = PH_HDR2;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR1;
            opcode_reg <= 4'h0;
            fin_reg    <= 1'b0;
            masked_reg <= 1'b0;
            len_reg    <= '0;
            ext_reg    <= 3'd0;
            key_reg    <= 32'h0;
            pos_reg    <= 2'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            fin_reg    <= fin_next;
            masked_reg <= masked_next;
            len_reg    <= len_next;
            ext_reg    <= ext_next;
            key_reg    <= key_next;
            pos_reg    <= pos_next;
        end
    end

    `WSD_ASSERT_ALWAYS(a_data_len_nonzero, clk, rst_n, (phase_reg != PH_DATA) || (len_reg != '0))
    `WSD_ASSERT_ALWAYS(a_push_only_data, clk, rst_n, !push || (phase_reg == PH_DATA && accept))

endmodule
`default_nettype wire

@@ hw/rtl/wsd_queue.sv @@
// Short queue of parsed payload requests between parser and output stage.
`default_nettype none
`include "assert_macros.svh"
module wsd_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire wsd_pkg::entry_t push_entry,
    input  wire logic            pop,
    output wsd_pkg::entry_t      head,
    output logic                 full,
    output logic                 empty
);

    localparam int PTR_W = $clog2(wsd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(wsd_pkg::QUEUE_DEPTH + 1);

    wsd_pkg::entry_t  slots_reg [wsd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(wsd_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    `WSD_ASSERT_ALWAYS(a_no_overflow, clk, rst_n, !(push && full))
    `WSD_ASSERT_ALWAYS(a_no_underflow, clk, rst_n, !(pop && empty))

endmodule
`default_nettype wire

@@ hw/rtl/wsd_back.sv @@
// Output stage: unmasks queued payload bytes into the result register.
`default_nettype none
`include "assert_macros.svh"
module wsd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire wsd_pkg::entry_t head,
    input  wire logic            empty,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [7:0]           payload_byte,
    output logic                 frame_kind,
    output logic                 final_fragment,
    output logic                 last_of_frame
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       kind_reg, fin_reg, last_reg;

    // advance when the result register is free or being taken
    assign pop = !empty && (!valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            byte_reg <= head.data ^ head.key_byte;
            kind_reg <= head.kind;
            fin_reg  <= head.fin;
            last_reg <= head.last;
        end
    end

    assign out_valid      = valid_reg;
    assign payload_byte   = byte_reg;
    assign frame_kind     = kind_reg;
    assign final_fragment = fin_reg;
    assign last_of_frame  = last_reg;

    `WSD_ASSERT_NEXT(a_pop_fills, clk, rst_n, pop, valid_reg)

endmodule
`default_nettype wire

@@ hw/rtl/websocket_frame_deframer_top.sv @@
// WebSocket frame deframer: top level.
// Input channel: one received byte per request (in_valid/in_ready, rx_byte),
// the raw stream of an established connection. The parser reads the frame
// header (FIN, opcode, mask bit, 7-bit length with 16- or 64-bit extension,
// 4-byte masking key) and sends each payload byte of a text or binary frame
// on the output channel (out_valid/out_ready) unmasked, with frame_kind
// (0 text, 1 binary), final_fragment (the frame's FIN) and last_of_frame.
// Header bytes and payloads of all other frames give no output.
// Throughput: one byte per cycle in and out while the queue has room and
// out_ready is high; header and payload bytes pass the parser at that rate.
// Path: a payload byte accepted by the parser is written into the queue, then
// moved into the output register behind out_valid when it is free or taken.
// Stall: a four-entry queue sits between parser and output register; when the
// receiver holds out_ready low the queue fills and then in_ready drops.
// Reset: rst_n clears the parser to expect a frame's first header byte and
// empties the queue and output register.
`default_nettype none
module websocket_frame_deframer_top #(
    parameter int LENGTH_BITS = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      payload_byte,
    output logic            frame_kind,
    output logic            final_fragment,
    output logic            last_of_frame
);

    wsd_pkg::entry_t push_entry;
    wsd_pkg::entry_t head;
    logic            push, pop, full, empty;

    wsd_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .queue_full (full),
        .push       (push),
        .push_entry (push_entry)
    );

    wsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .empty      (empty)
    );

    wsd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .empty          (empty),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .payload_byte   (payload_byte),
        .frame_kind     (frame_kind),
        .final_fragment (final_fragment),
        .last_of_frame  (last_of_frame)
    );

endmodule
`default_nettype wire

@@ bench/tb_websocket_frame_deframer_top.sv @@
// Self-checking testbench for the WebSocket frame deframer top level.
module tb_websocket_frame_deframer_top;

    localparam int PRED_LEN_BITS = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int BYTES_PER_PHASE = 150;
    localparam int MAX_REPORTS = 10;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    typedef enum logic [2:0] {
        AWAIT_HDR1,
        AWAIT_HDR2,
        READ_EXT_LEN,
        READ_KEY,
        READ_PAYLOAD
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       kind;
        logic       fin;
        logic       last;
    } payload_t;

    typedef struct {
        logic [7:0] rx;
        bit         typed;
        payload_t   want;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] payload_byte;
    logic       frame_kind;
    logic       final_fragment;
    logic       last_of_frame;

    websocket_frame_deframer_top #(.LENGTH_BITS(PRED_LEN_BITS)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .payload_byte   (payload_byte),
        .frame_kind     (frame_kind),
        .final_fragment (final_fragment),
        .last_of_frame  (last_of_frame)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Deframer state as the bench sees it
    parse_phase_t             phase_q = AWAIT_HDR1;
    logic [3:0]               op_q = '0;
    logic                     fin_q = 1'b0;
    logic                     masked_q = 1'b0;
    logic [PRED_LEN_BITS-1:0] len_left = '0;
    logic [2:0]               ext_left = '0;
    logic [31:0]              key_q = '0;
    logic [1:0]               pos_q = '0;

    payload_t  expected_bytes[$];
    stim_row_t stim_rows[$];
    int        errors = 0;
    int        bytes_sent = 0;
    int        cycle_count = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;

    function automatic void finish_header();
        pos_q = 2'd0;
        phase_q = (len_left != 0) ? READ_PAYLOAD : AWAIT_HDR1;
    endfunction

    function automatic void finish_length();
        if (masked_q)
        begin
            pos_q = 2'd0;
            phase_q = READ_KEY;
        end
        else
            finish_header();
    endfunction

    // Advance the parser by one byte; return 1 when a payload byte comes out.
    function automatic bit deframe_byte(input logic [7:0] b, output payload_t res);
        logic [7:0] kb;
        bit emit;
        bit last;
        res = '0;
        case (phase_q)
            AWAIT_HDR2:
            begin
                masked_q = b[7];
                key_q = '0;
                len_left = '0;
                if (b[6:0] == wsd_pkg::LEN16_CODE)
                begin
                    ext_left = 3'd2;
                    phase_q = READ_EXT_LEN;
                end
                else if (b[6:0] == wsd_pkg::LEN64_CODE)
                begin
                    // eight bytes wrap to zero in the three-bit counter
                    ext_left = 3'd0;
                    phase_q = READ_EXT_LEN;
                end
                else
                begin
                    len_left = PRED_LEN_BITS'(b[6:0]);
                    finish_length();
                end
                return 1'b0;
            end
            READ_EXT_LEN:
            begin
                len_left = {len_left[PRED_LEN_BITS-9:0], b};
                ext_left = ext_left - 3'd1;
                if (ext_left == 3'd0)
                    finish_length();
                return 1'b0;
            end
            READ_KEY:
            begin
                key_q = {key_q[23:0], b};
                if (pos_q == 2'd3)
                    finish_header();
                else
                    pos_q = pos_q + 2'd1;
                return 1'b0;
            end
            READ_PAYLOAD:
            begin
                emit = (op_q == wsd_pkg::OP_TEXT) || (op_q == wsd_pkg::OP_BINARY);
                last = (len_left == 1);
                kb = masked_q ? key_q[8*(3-pos_q) +: 8] : 8'h00;
                pos_q = pos_q + 2'd1;
                len_left = len_left - 1'b1;
                if (len_left == 0)
                    phase_q = AWAIT_HDR1;
                res.data = b ^ kb;
                res.kind = (op_q == wsd_pkg::OP_BINARY);
                res.fin = fin_q;
                res.last = last;
                return emit;
            end
            default:
            begin
                fin_q = b[7];
                op_q = b[3:0];
                phase_q = AWAIT_HDR2;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        errors = errors + 1;
        if (errors <= MAX_REPORTS)
            $display("mismatch %s: expected %0d, got %0d at cycle %0d",
                     what, want, got, cycle_count);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[websocket_frame_deframer_top] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin : check_output
        payload_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
                flag_mismatch("unexpected payload_byte", -1, payload_byte);
            else
            begin
                want = expected_bytes.pop_front();
                if (payload_byte !== want.data)
                    flag_mismatch("payload_byte", want.data, payload_byte);
                if (frame_kind !== want.kind)
                    flag_mismatch("frame_kind", want.kind, frame_kind);
                if (final_fragment !== want.fin)
                    flag_mismatch("final_fragment", want.fin, final_fragment);
                if (last_of_frame !== want.last)
                    flag_mismatch("last_of_frame", want.last, last_of_frame);
            end
        end
    end

    // Present one byte, hold it until the request is taken, then predict.
    task automatic drive_byte(input logic [7:0] b, input bit typed = 1'b0,
                              input payload_t want = '0);
        payload_t res;
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent = bytes_sent + 1;
        if (deframe_byte(b, res) && !typed)
            expected_bytes.push_back(res);
        if (typed)
            expected_bytes.push_back(want);
    endtask

    task automatic add_row(input logic [7:0] b, input bit typed = 1'b0,
                           input logic [7:0] data = 8'h00, input logic kind = 1'b0,
                           input logic fin = 1'b0, input logic last = 1'b0);
        stim_row_t row;
        row.rx = b;
        row.typed = typed;
        row.want = '{data: data, kind: kind, fin: fin, last: last};
        stim_rows.push_back(row);
    endtask

    // Drop valid for at least one edge and hold until every result is out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
    endtask

    // One frame with random content; noisy frames carry any first header byte.
    task automatic send_frame(input bit noisy);
        logic [7:0] hdr1;
        logic [3:0] op;
        logic [15:0] plen;
        bit masked;
        int pick;
        int form;
        masked = 1'($urandom_range(1));
        pick = $urandom_range(19);
        if (pick < 8)
            op = wsd_pkg::OP_TEXT;
        else if (pick < 16)
            op = wsd_pkg::OP_BINARY;
        else if (pick == 16)
            op = OP_CONT;
        else if (pick == 17)
            op = OP_CLOSE;
        else if (pick == 18)
            op = OP_PING;
        else
            op = OP_PONG;
        hdr1 = noisy ? 8'($urandom_range(255)) : {1'($urandom_range(1)), 3'b000, op};
        drive_byte(hdr1);
        form = $urandom_range(99);
        if (form < 70)
        begin
            pick = $urandom_range(19);
            if (pick == 0)
                plen = 16'd125;
            else if (pick < 3)
                plen = 16'($urandom_range(124, 13));
            else
                plen = 16'($urandom_range(12));
            drive_byte({masked, plen[6:0]});
        end
        else if (form < 85)
        begin
            plen = ($urandom_range(9) == 0) ? 16'($urandom_range(300, 100))
                                            : 16'($urandom_range(40));
            drive_byte({masked, wsd_pkg::LEN16_CODE});
            drive_byte(plen[15:8]);
            drive_byte(plen[7:0]);
        end
        else
        begin
            plen = 16'($urandom_range(40));
            drive_byte({masked, wsd_pkg::LEN64_CODE});
            repeat (6)
                drive_byte(8'h00);
            drive_byte(plen[15:8]);
            drive_byte(plen[7:0]);
        end
        if (masked)
            repeat (4)
                drive_byte(8'($urandom_range(255)));
        repeat (int'(plen))
            drive_byte(8'($urandom_range(255)));
    endtask

    initial
    begin
        int start_count;
        // text, FIN, reserved bits set, unmasked, payload extremes
        add_row(8'hF1);
        add_row(8'h02);
        add_row(8'h00, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0);
        add_row(8'hFF, 1'b1, 8'hFF, 1'b0, 1'b1, 1'b1);
        // binary, not final, masked, one byte
        add_row(8'h02);
        add_row(8'h81);
        add_row(8'hAA);
        add_row(8'hBB);
        add_row(8'hCC);
        add_row(8'hDD);
        add_row(8'h55, 1'b1, 8'hFF, 1'b1, 1'b0, 1'b1);
        // masked text frame with empty payload
        add_row(8'h81);
        add_row(8'h80);
        add_row(8'h11);
        add_row(8'h22);
        add_row(8'h33);
        add_row(8'h44);
        // close frame: payload dropped
        add_row({1'b1, 3'b000, OP_CLOSE});
        add_row(8'h01);
        add_row(8'h33);
        // binary with a non-minimal 16-bit length of one
        add_row(8'h82);
        add_row({1'b0, wsd_pkg::LEN16_CODE});
        add_row(8'h00);
        add_row(8'h01);
        add_row(8'h41, 1'b1, 8'h41, 1'b1, 1'b1, 1'b1);

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
            drive_byte(stim_rows[i].rx, stim_rows[i].typed, stim_rows[i].want);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 61; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase
            start_count = bytes_sent;
            while (bytes_sent - start_count < BYTES_PER_PHASE)
                send_frame($urandom_range(9) == 0);
            // hold off the sender until every payload byte is out
            wait_drained();
        end

        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (errors == 0 && expected_bytes.size() == 0)
            $display("[websocket_frame_deframer_top] OK");
        else
            $display("[websocket_frame_deframer_top] ERROR");
        $finish;
    end

endmodule
